// ----- rtl/obb_pkg.sv -----
package obb_pkg;

	localparam int COORD_W = 32;
	localparam int QF = 14;
	localparam int QW = 16;
	localparam int HALF_W = COORD_W - 1;
	localparam int DIFF_W = COORD_W + 1;
	localparam int ACC_W = COORD_W + 8;
	localparam int PROD_W = 2 * QW;
	localparam int WIDE_W = COORD_W + QW + 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef logic signed [QW-1:0] word_t;
	typedef logic [QW-1:0] mag_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t WMAX = (wide_t'(1) <<< (QW - 1)) - wide_t'(1);
	localparam wide_t WMIN = -WMAX - wide_t'(1);

	// round half away from zero, dropping QF fraction bits
	function automatic wide_t rnd_q(input wide_t v);
		logic [WIDE_W-1:0] mag;
		mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		mag = (mag + (WIDE_W'(1) << (QF - 1))) >> QF;
		return v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic word_t sat_w(input wide_t v);
		wide_t r;
		r = v;
		if (v > WMAX)
			r = WMAX;
		else if (v < WMIN)
			r = WMIN;
		return r[QW-1:0];
	endfunction

	function automatic mag_t mag_w(input word_t v);
		return v[QW-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	function automatic acc_t abs_a(input acc_t v);
		return v[ACC_W-1] ? -v : v;
	endfunction

	localparam word_t ONE_W = sat_w(wide_t'(1) <<< QF);

endpackage

// ----- rtl/obb_overlap_test.sv -----
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   command, center_x..z, half_x..z, quat_x..w
// out      output     out_valid / out_stall overlap
//
// One word enters per cycle unless in_stall is high; each test word gives one result.
// Load words update the reference box in stage 2 and give no result.
// Reset clears the pipeline and sets a zero-size reference box at the origin.
// A stalled result holds the whole pipeline; in_stall follows out_stall then.
module obb_overlap_test import obb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   command,
	input  coord_t center_x,
	input  coord_t center_y,
	input  coord_t center_z,
	input  half_t  half_x,
	input  half_t  half_y,
	input  half_t  half_z,
	input  word_t  quat_x,
	input  word_t  quat_y,
	input  word_t  quat_z,
	input  word_t  quat_w,
	output logic   out_valid,
	input  logic   out_stall,
	output logic   overlap
);

	logic en;
	logic vld_s1, vld_s2;
	logic tst_s3, tst_s4, tst_s5, tst_s6, tst_s7, tst_s8, vld_s9;
	logic cmd_s1, cmd_s2;
	coord_t ctr_s1 [3];
	coord_t ctr_s2 [3];
	half_t half_s1 [3];
	half_t half_s2 [3];
	word_t qx_s1, qy_s1, qz_s1, qw_s1;
	word_t ax [9];

	coord_t ref_center_q [3];
	half_t ref_half_q [3];
	word_t ref_axis_q [9];

	word_t a_s3 [9];
	word_t b_s3 [9];
	diff_t d_s3 [3];
	half_t ha_s3 [3];
	half_t hb_s3 [3];
	logic sep;
	logic overlap_s9;

	assign en = !(vld_s9 && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s9;
	assign overlap = overlap_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			tst_s3 <= 1'b0;
			tst_s4 <= 1'b0;
			tst_s5 <= 1'b0;
			tst_s6 <= 1'b0;
			tst_s7 <= 1'b0;
			tst_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			tst_s3 <= vld_s2 && (cmd_s2 == CMD_TEST);
			tst_s4 <= tst_s3;
			tst_s5 <= tst_s4;
			tst_s6 <= tst_s5;
			tst_s7 <= tst_s6;
			tst_s8 <= tst_s7;
			vld_s9 <= tst_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= command;
			ctr_s1[0] <= center_x;
			ctr_s1[1] <= center_y;
			ctr_s1[2] <= center_z;
			half_s1[0] <= half_x;
			half_s1[1] <= half_y;
			half_s1[2] <= half_z;
			qx_s1 <= quat_x;
			qy_s1 <= quat_y;
			qz_s1 <= quat_z;
			qw_s1 <= quat_w;
			cmd_s2 <= cmd_s1;
			ctr_s2 <= ctr_s1;
			half_s2 <= half_s1;
		end
	end

	obb_quat u_quat (
		.clk (clk),
		.en  (en),
		.qx  (qx_s1),
		.qy  (qy_s1),
		.qz  (qz_s1),
		.qw  (qw_s1),
		.ax  (ax)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_center_q[k] <= '0;
				ref_half_q[k] <= '0;
			end
			for (int n = 0; n < 9; n++)
				ref_axis_q[n] <= (n % 4 == 0) ? ONE_W : '0;
		end else if (en && vld_s2 && (cmd_s2 == CMD_LOAD)) begin
			ref_center_q <= ctr_s2;
			ref_half_q <= half_s2;
			ref_axis_q <= ax;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= ref_axis_q;
			b_s3 <= ax;
			for (int k = 0; k < 3; k++)
				d_s3[k] <= diff_t'(ref_center_q[k]) - diff_t'(ctr_s2[k]);
			ha_s3 <= ref_half_q;
			hb_s3 <= half_s2;
		end
	end

	obb_sep u_sep (
		.clk (clk),
		.en  (en),
		.a   (a_s3),
		.b   (b_s3),
		.d   (d_s3),
		.ha  (ha_s3),
		.hb  (hb_s3),
		.sep (sep)
	);

	always_ff @(posedge clk) begin
		if (en)
			overlap_s9 <= !sep;
	end

endmodule

// ----- rtl/obb_quat.sv -----
module obb_quat import obb_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t qx,
	input  word_t qy,
	input  word_t qz,
	input  word_t qw,
	output word_t ax [9]
);

	prod_t xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, xw_s2, yw_s2, zw_s2;
	wide_t one_m;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= qx * qx;
			yy_s2 <= qy * qy;
			zz_s2 <= qz * qz;
			xy_s2 <= qx * qy;
			xz_s2 <= qx * qz;
			yz_s2 <= qy * qz;
			xw_s2 <= qx * qw;
			yw_s2 <= qy * qw;
			zw_s2 <= qz * qw;
		end
	end

	assign one_m = wide_t'(1) <<< (2 * QF);

	always_comb begin
		ax[0] = sat_w(rnd_q(one_m - wide_t'(2) * (wide_t'(yy_s2) + wide_t'(zz_s2))));
		ax[1] = sat_w(rnd_q(wide_t'(2) * (wide_t'(xy_s2) + wide_t'(zw_s2))));
		ax[2] = sat_w(rnd_q(wide_t'(2) * (wide_t'(xz_s2) - wide_t'(yw_s2))));
		ax[3] = sat_w(rnd_q(wide_t'(2) * (wide_t'(xy_s2) - wide_t'(zw_s2))));
		ax[4] = sat_w(rnd_q(one_m - wide_t'(2) * (wide_t'(xx_s2) + wide_t'(zz_s2))));
		ax[5] = sat_w(rnd_q(wide_t'(2) * (wide_t'(yz_s2) + wide_t'(xw_s2))));
		ax[6] = sat_w(rnd_q(wide_t'(2) * (wide_t'(xz_s2) + wide_t'(yw_s2))));
		ax[7] = sat_w(rnd_q(wide_t'(2) * (wide_t'(yz_s2) - wide_t'(xw_s2))));
		ax[8] = sat_w(rnd_q(one_m - wide_t'(2) * (wide_t'(xx_s2) + wide_t'(yy_s2))));
	end

endmodule

// ----- rtl/obb_sep.sv -----
module obb_sep import obb_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t a [9],
	input  word_t b [9],
	input  diff_t d [3],
	input  half_t ha [3],
	input  half_t hb [3],
	output logic  sep
);

	// stage 4
	prod_t rp_s4 [3][3][3];
	prod_t cp_s4 [3][3][6];
	acc_t  lfa_s4 [3][3];
	acc_t  lfb_s4 [3][3];
	word_t a_s4 [9];
	word_t b_s4 [9];
	diff_t d_s4 [3];
	half_t ha_s4 [3];
	half_t hb_s4 [3];

	// stage 5
	word_t r_s5 [3][3];
	word_t u_s5 [3][3][3];
	acc_t  la_s5 [3];
	acc_t  lb_s5 [3];
	word_t a_s5 [9];
	word_t b_s5 [9];
	diff_t d_s5 [3];
	half_t ha_s5 [3];
	half_t hb_s5 [3];

	// stage 6
	acc_t  fa_s6 [3][3];
	acc_t  fb_s6 [3][3];
	acc_t  la_s6 [3];
	acc_t  lb_s6 [3];
	prod_t pa_s6 [3][3][3][3];
	prod_t pb_s6 [3][3][3][3];
	acc_t  lu_s6 [3][3][3];
	half_t ha_s6 [3];
	half_t hb_s6 [3];

	// stage 7
	logic [5:0] sepf_s7;
	mag_t  da_s7 [3][3][3];
	mag_t  db_s7 [3][3][3];
	acc_t  lc_s7 [3][3];
	half_t ha_s7 [3];
	half_t hb_s7 [3];

	// stage 8
	logic [5:0] sepf_s8;
	acc_t  xa_s8 [3][3][3];
	acc_t  xb_s8 [3][3][3];
	acc_t  lc_s8 [3][3];

	logic [8:0] sepc;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++)
						rp_s4[i][j][k] <= a[3*i+k] * b[3*j+k];
					cp_s4[i][j][0] <= a[3*i+1] * b[3*j+2];
					cp_s4[i][j][1] <= a[3*i+2] * b[3*j+1];
					cp_s4[i][j][2] <= a[3*i+2] * b[3*j];
					cp_s4[i][j][3] <= a[3*i] * b[3*j+2];
					cp_s4[i][j][4] <= a[3*i] * b[3*j+1];
					cp_s4[i][j][5] <= a[3*i+1] * b[3*j];
				end
				for (int k = 0; k < 3; k++) begin
					lfa_s4[i][k] <= acc_t'(rnd_q(d[k] * a[3*i+k]));
					lfb_s4[i][k] <= acc_t'(rnd_q(d[k] * b[3*i+k]));
				end
			end
			a_s4 <= a;
			b_s4 <= b;
			d_s4 <= d;
			ha_s4 <= ha;
			hb_s4 <= hb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s5[i][j] <= sat_w(rnd_q(wide_t'(rp_s4[i][j][0])
						+ wide_t'(rp_s4[i][j][1]) + wide_t'(rp_s4[i][j][2])));
					for (int c = 0; c < 3; c++)
						u_s5[i][j][c] <= sat_w(rnd_q(wide_t'(cp_s4[i][j][2*c])
							- wide_t'(cp_s4[i][j][2*c+1])));
				end
				la_s5[i] <= lfa_s4[i][0] + lfa_s4[i][1] + lfa_s4[i][2];
				lb_s5[i] <= lfb_s4[i][0] + lfb_s4[i][1] + lfb_s4[i][2];
			end
			a_s5 <= a_s4;
			b_s5 <= b_s4;
			d_s5 <= d_s4;
			ha_s5 <= ha_s4;
			hb_s5 <= hb_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					fa_s6[i][k] <= acc_t'(rnd_q(hb_s5[k] * mag_w(r_s5[i][k])));
					fb_s6[i][k] <= acc_t'(rnd_q(ha_s5[k] * mag_w(r_s5[k][i])));
				end
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++)
						for (int t = 0; t < 3; t++) begin
							pa_s6[i][j][k][t] <= u_s5[i][j][t] * a_s5[3*k+t];
							pb_s6[i][j][k][t] <= u_s5[i][j][t] * b_s5[3*k+t];
						end
					for (int t = 0; t < 3; t++)
						lu_s6[i][j][t] <= acc_t'(rnd_q(d_s5[t] * u_s5[i][j][t]));
				end
			end
			la_s6 <= la_s5;
			lb_s6 <= lb_s5;
			ha_s6 <= ha_s5;
			hb_s6 <= hb_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sepf_s7[i] <= abs_a(la_s6[i]) > acc_t'(ha_s6[i])
					+ fa_s6[i][0] + fa_s6[i][1] + fa_s6[i][2];
				sepf_s7[3+i] <= abs_a(lb_s6[i]) > acc_t'(hb_s6[i])
					+ fb_s6[i][0] + fb_s6[i][1] + fb_s6[i][2];
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						da_s7[i][j][k] <= mag_w(sat_w(rnd_q(wide_t'(pa_s6[i][j][k][0])
							+ wide_t'(pa_s6[i][j][k][1]) + wide_t'(pa_s6[i][j][k][2]))));
						db_s7[i][j][k] <= mag_w(sat_w(rnd_q(wide_t'(pb_s6[i][j][k][0])
							+ wide_t'(pb_s6[i][j][k][1]) + wide_t'(pb_s6[i][j][k][2]))));
					end
					lc_s7[i][j] <= lu_s6[i][j][0] + lu_s6[i][j][1] + lu_s6[i][j][2];
				end
			end
			ha_s7 <= ha_s6;
			hb_s7 <= hb_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					for (int k = 0; k < 3; k++) begin
						xa_s8[i][j][k] <= acc_t'(rnd_q(ha_s7[k] * da_s7[i][j][k]));
						xb_s8[i][j][k] <= acc_t'(rnd_q(hb_s7[k] * db_s7[i][j][k]));
					end
			lc_s8 <= lc_s7;
			sepf_s8 <= sepf_s7;
		end
	end

	// drop the edge used in each cross product from its own box's radius
	always_comb begin
		acc_t rsum;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				rsum = '0;
				for (int k = 0; k < 3; k++) begin
					if (k != i)
						rsum = rsum + xa_s8[i][j][k];
					if (k != j)
						rsum = rsum + xb_s8[i][j][k];
				end
				sepc[3*i+j] = abs_a(lc_s8[i][j]) > rsum;
			end
	end

	assign sep = (|sepf_s8) | (|sepc);

endmodule

// ----- rtl/obb_chk.sv -----
module obb_chk import obb_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_stall,
	input logic   command,
	input logic   out_valid,
	input logic   out_stall,
	input logic   overlap
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(overlap))
		else $error("result word changed under stall");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 9) && $past(in_valid && !in_stall && (command == CMD_TEST), 9)
		&& !$past(in_stall, 1) && !$past(in_stall, 2) && !$past(in_stall, 3)
		&& !$past(in_stall, 4) && !$past(in_stall, 5) && !$past(in_stall, 6)
		&& !$past(in_stall, 7) && !$past(in_stall, 8) |-> out_valid)
		else $error("test word gave no result after nine cycles");

endmodule

bind obb_overlap_test obb_chk u_chk (.*);

// ----- tb/obb_overlap_checker.sv -----
`timescale 1ns / 100ps
module obb_overlap_checker import obb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_stall,
	input  logic   command,
	input  coord_t center_x,
	input  coord_t center_y,
	input  coord_t center_z,
	input  half_t  half_x,
	input  half_t  half_y,
	input  half_t  half_z,
	input  word_t  quat_x,
	input  word_t  quat_y,
	input  word_t  quat_z,
	input  word_t  quat_w,
	input  logic   out_valid,
	input  logic   out_stall,
	input  logic   overlap,
	output int     errors,
	output int     pending
);

	longint box_ctr[3];
	longint box_half[3];
	longint box_axis[9];
	bit overlap_q[$];

	function automatic longint round_q(longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 << (QF - 1))) >>> QF;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clip_w(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint dot_w(longint a0, longint a1, longint a2,
			longint b0, longint b1, longint b2);
		return clip_w(round_q(a0 * b0 + a1 * b1 + a2 * b2));
	endfunction

	function automatic longint box_radius(longint ext[3], longint ax[9], longint u[3],
			int face, int skip);
		longint r;
		r = 0;
		if (face >= 0) return ext[face];
		for (int k = 0; k < 3; k++)
			if (k != skip)
				r += round_q(ext[k] * absl(dot_w(u[0], u[1], u[2],
					ax[3*k], ax[3*k+1], ax[3*k+2])));
		return r;
	endfunction

	function automatic bit apart(longint u[3], longint d[3], longint ra, longint rb);
		longint l;
		l = round_q(d[0] * u[0]) + round_q(d[1] * u[1]) + round_q(d[2] * u[2]);
		return absl(l) > ra + rb;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint ctr[3], hf[3], ax[9], m[9], d[3], u[3], a[3], b[3];
		longint x, y, z, w, one;
		bit sep;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_ctr[i] = 0;
				box_half[i] = 0;
			end
			for (int i = 0; i < 9; i++)
				box_axis[i] = (i % 4 == 0) ? longint'(ONE_W) : 0;
			overlap_q.delete();
			errors <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (overlap_q.size() == 0) begin
					$error("unexpected result word overlap=%0b", overlap);
					errors <= errors + 1;
				end else begin
					sep = overlap_q.pop_front();
					if (overlap !== sep) begin
						$error("overlap: expected %0b actual %0b", sep, overlap);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				ctr[0] = center_x; ctr[1] = center_y; ctr[2] = center_z;
				hf[0] = half_x; hf[1] = half_y; hf[2] = half_z;
				x = quat_x; y = quat_y; z = quat_z; w = quat_w;
				one = 64'sd1 << (2 * QF);
				m[0] = one - 2 * (y * y + z * z);
				m[1] = 2 * (x * y + z * w);
				m[2] = 2 * (x * z - y * w);
				m[3] = 2 * (x * y - z * w);
				m[4] = one - 2 * (x * x + z * z);
				m[5] = 2 * (y * z + x * w);
				m[6] = 2 * (x * z + y * w);
				m[7] = 2 * (y * z - x * w);
				m[8] = one - 2 * (x * x + y * y);
				for (int i = 0; i < 9; i++) ax[i] = clip_w(round_q(m[i]));
				if (command == CMD_LOAD) begin
					box_ctr = ctr;
					box_half = hf;
					box_axis = ax;
				end else begin
					sep = 0;
					for (int i = 0; i < 3; i++) d[i] = box_ctr[i] - ctr[i];
					for (int i = 0; i < 3 && !sep; i++) begin
						for (int k = 0; k < 3; k++) u[k] = box_axis[3*i+k];
						sep = apart(u, d, box_radius(box_half, box_axis, u, i, -1),
							box_radius(hf, ax, u, -1, -1));
					end
					for (int j = 0; j < 3 && !sep; j++) begin
						for (int k = 0; k < 3; k++) u[k] = ax[3*j+k];
						sep = apart(u, d, box_radius(box_half, box_axis, u, -1, -1),
							box_radius(hf, ax, u, j, -1));
					end
					for (int i = 0; i < 3 && !sep; i++)
						for (int j = 0; j < 3 && !sep; j++) begin
							for (int k = 0; k < 3; k++) begin
								a[k] = box_axis[3*i+k];
								b[k] = ax[3*j+k];
							end
							u[0] = clip_w(round_q(a[1] * b[2] - a[2] * b[1]));
							u[1] = clip_w(round_q(a[2] * b[0] - a[0] * b[2]));
							u[2] = clip_w(round_q(a[0] * b[1] - a[1] * b[0]));
							sep = apart(u, d, box_radius(box_half, box_axis, u, -1, i),
								box_radius(hf, ax, u, -1, j));
						end
					overlap_q.push_back(!sep);
				end
			end
		end
	end

	assign pending = overlap_q.size();

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench import obb_pkg::*; ();

	localparam int LATENCY = 12;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM = 2000;

	logic clk, arst_n, in_valid, in_stall, command, out_valid, out_stall, overlap;
	coord_t center_x, center_y, center_z;
	half_t half_x, half_y, half_z;
	word_t quat_x, quat_y, quat_z, quat_w;
	int errors, pending, idle_cycles;
	bit quiet;

	obb_overlap_test uut (.*);

	obb_overlap_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (quiet || $urandom_range(0, 5) != 0)
			out_stall <= 0;
		else begin
			out_stall <= 1;
			repeat ($urandom_range(1, 4) - 1) @(posedge clk);
		end
	end

	function automatic word_t pick_quat();
		case ($urandom_range(0, 3))
			0: return word_t'(16384);
			1: return word_t'(-16384);
			2: return word_t'(0);
			default: return word_t'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	task automatic send(logic cmd, coord_t cx, coord_t cy, coord_t cz,
			half_t hx, half_t hy, half_t hz, word_t qx, word_t qy, word_t qz, word_t qw);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		center_x <= cx; center_y <= cy; center_z <= cz;
		half_x <= hx; half_y <= hy; half_z <= hz;
		quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(logic cmd);
		coord_t c[3];
		half_t h[3];
		int sc;
		sc = $urandom_range(0, 7);
		for (int i = 0; i < 3; i++) begin
			c[i] = (sc == 0) ? coord_t'($urandom()) : $signed($urandom_range(0, 32'h000a0000))
				- 32'sh00050000;
			h[i] = (sc == 1) ? half_t'($urandom()) : half_t'($urandom_range(0, 32'h00030000));
		end
		send(cmd, c[0], c[1], c[2], h[0], h[1], h[2],
			pick_quat(), pick_quat(), pick_quat(), pick_quat());
	endtask

	initial begin
		in_valid = 0; command = 0; out_stall = 0; quiet = 0;
		center_x = 0; center_y = 0; center_z = 0;
		half_x = 0; half_y = 0; half_z = 0;
		quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0;
		idle_cycles = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16384);
		send(CMD_TEST, 32'sh00010000, 0, 0, 0, 0, 0, 0, 0, 0, 16384);
		send(CMD_LOAD, 0, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000, 0, 0, 0, 16384);
		send(CMD_TEST, 32'sh00020000, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000,
			0, 0, 0, 16384);
		send(CMD_TEST, 32'sh00020001, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000,
			0, 0, 0, 16384);
		send(CMD_TEST, 32'sh00020000, 32'sh00020000, 0, 31'h00010000, 31'h00010000,
			31'h00010000, 0, 0, 11585, 11585);
		send(CMD_TEST, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 16384, 0, 0, 0);
		send(CMD_TEST, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0,
			-16384, -16384, -16384, -16384);
		send(CMD_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 16384, 16384, 16384, 16384);
		send(CMD_TEST, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 16384, 16384, 16384, 16384);
		send(CMD_TEST, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, -16384, 16384, -16384, 16384);
		send(CMD_LOAD, 0, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000, 0, 0, 11585, 11585);
		send(CMD_TEST, 32'sh00010000, 0, 0, 31'h00010000, 31'h00010000, 31'h00010000,
			0, 0, 11585, 11585);
		send(CMD_TEST, 32'sh00030000, 32'sh00030000, 0, 31'h00010000, 31'h00010000,
			31'h00010000, 9459, 9459, 9459, 9459);
		send(CMD_TEST, -32'sh00001000, 32'sh00001000, 32'sh00002000, 31'h00000800,
			31'h00020000, 31'h00000100, 8192, -8192, 8192, -8192);
		in_valid <= 0;
		wait (pending == 0);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 200) quiet = 1;
			send_random(($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_TEST);
		end
		in_valid <= 0;
		wait (pending == 0);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
